FILE: hdl/gss_pkg.sv
// Package for the 3x3 Gauss-Seidel solver: transaction payload types,
// status and register codes, fixed widths and reset values.
// No dependencies.
package gss_pkg;

  localparam int DATA_W       = 32;
  localparam int CNT_W        = 16;
  localparam int NUM_W        = 40;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_MAXIT = 1'b1;

  localparam logic [31:0]      TOL_RESET   = 32'd42950;
  localparam logic [CNT_W-1:0] MAXIT_RESET = 16'd1000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_start;
    logic signed [DATA_W-1:0] y_start;
    logic signed [DATA_W-1:0] z_start;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_result;
    logic signed [DATA_W-1:0] y_result;
    logic signed [DATA_W-1:0] z_result;
    logic [CNT_W-1:0]         sweep_count;
    logic [1:0]               status;
  } out_t;

endpackage

FILE: hdl/gss_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on gss_pkg for the data width.
module gss_mul
  import gss_pkg::*;
(
  input  logic                  clk,
  input  logic [DATA_W-1:0]     op_a,
  input  logic [DATA_W-1:0]     op_b,
  output logic [2*DATA_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

FILE: hdl/gss_seq.sv
// Sweep sequencer and datapath: runs x, y, z updates and the convergence
// test through the shared multiplier. Depends on gss_pkg and gss_mul.
module gss_seq
  import gss_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_t              item,
  input  logic [31:0]      tol,
  input  logic [CNT_W-1:0] max_it,
  output logic             busy,
  output logic             done_valid,
  input  logic             done_ready,
  output out_t             result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NUM  = 4'd1;
  localparam logic [3:0] S_LO   = 4'd2;
  localparam logic [3:0] S_HI   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_CX   = 4'd6;
  localparam logic [3:0] S_CXW  = 4'd7;
  localparam logic [3:0] S_CY   = 4'd8;
  localparam logic [3:0] S_CYW  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam logic [1:0] PH_X = 2'd0;
  localparam logic [1:0] PH_Y = 2'd1;
  localparam logic [1:0] PH_Z = 2'd2;

  localparam logic [31:0] RECIP6  = 32'(((64'd1 << (FRAC_BITS + 1)) + 64'd6) / 64'd12);
  localparam logic [31:0] RECIP9  = 32'(((64'd1 << (FRAC_BITS + 1)) + 64'd9) / 64'd18);
  localparam logic [31:0] RECIP12 = 32'(((64'd1 << (FRAC_BITS + 1)) + 64'd12) / 64'd24);
  localparam logic [63:0] HALF    = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h0000_0000_8000_0000;
  localparam logic signed [NUM_W-1:0] K3  = NUM_W'(64'd3 << FRAC_BITS);
  localparam logic signed [NUM_W-1:0] K40 = NUM_W'(64'd40 << FRAC_BITS);
  localparam logic signed [NUM_W-1:0] K50 = NUM_W'(64'd50 << FRAC_BITS);

  logic [3:0]               state_r, state_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic signed [DATA_W-1:0] x_r, y_r, z_r, xo_r, yo_r;
  logic [CNT_W-1:0]         count_r;
  logic                     ovf_r, passx_r, numneg_r;
  logic [1:0]               status_r;
  logic [NUM_W-1:0]         mag_r;
  logic [63:0]              acc_r;

  logic [DATA_W-1:0]        mul_a, mul_b;
  logic [2*DATA_W-1:0]      prod;
  logic [31:0]              recip;

  logic signed [NUM_W-1:0]  ex, ey, ez, num;
  logic [63:0]              q, qs;
  logic                     negative, sat;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W:0]   dx, dy;
  logic [DATA_W:0]          adx, ady;
  logic                     pass_now;

  gss_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  always_comb begin
    ex = NUM_W'(x_r);
    ey = NUM_W'(y_r);
    ez = NUM_W'(z_r);
    case (phase_r)
      PH_X:    num = K3 - ey - ez;
      PH_Y:    num = K40 - ((ex <<< 2) + (ex <<< 1)) - ez;
      default: num = K50 + ((ex <<< 1) + ex) - ey;
    endcase
    case (phase_r)
      PH_X:    recip = RECIP6;
      PH_Y:    recip = RECIP9;
      default: recip = RECIP12;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LO: begin
        mul_a = mag_r[DATA_W-1:0];
        mul_b = recip;
      end
      S_HI: begin
        mul_a = DATA_W'(mag_r[NUM_W-1:DATA_W]);
        mul_b = recip;
      end
      S_CX: begin
        mul_a = tol;
        mul_b = xo_r[DATA_W-1] ? DATA_W'(-xo_r) : DATA_W'(xo_r);
      end
      S_CY: begin
        mul_a = tol;
        mul_b = yo_r[DATA_W-1] ? DATA_W'(-yo_r) : DATA_W'(yo_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    q        = (acc_r + HALF) >> FRAC_BITS;
    negative = numneg_r ^ (phase_r == PH_Z);
    sat      = negative ? (q > NEG_LIM) : (q > POS_LIM);
    qs       = sat ? (negative ? NEG_LIM : POS_LIM) : q;
    val      = negative ? DATA_W'(-qs[DATA_W-1:0]) : DATA_W'(qs[DATA_W-1:0]);
    dx       = (DATA_W+1)'(xo_r) - (DATA_W+1)'(x_r);
    dy       = (DATA_W+1)'(yo_r) - (DATA_W+1)'(y_r);
    adx      = dx[DATA_W] ? (DATA_W+1)'(-dx) : (DATA_W+1)'(dx);
    ady      = dy[DATA_W] ? (DATA_W+1)'(-dy) : (DATA_W+1)'(dy);
    pass_now = (state_r == S_CXW) ? ({adx[DATA_W-1:0], 32'b0} <= prod)
                                  : ({ady[DATA_W-1:0], 32'b0} <= prod);
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      S_IDLE:  if (start) begin
        state_nxt = S_NUM;
        phase_nxt = PH_X;
      end
      S_NUM:   state_nxt = S_LO;
      S_LO:    state_nxt = S_HI;
      S_HI:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_FIN;
      S_FIN: begin
        if (phase_r == PH_Z) begin
          state_nxt = S_CX;
        end else begin
          state_nxt = S_NUM;
          phase_nxt = phase_r + 2'd1;
        end
      end
      S_CX:    state_nxt = S_CXW;
      S_CXW:   state_nxt = S_CY;
      S_CY:    state_nxt = S_CYW;
      S_CYW: begin
        if (ovf_r || (passx_r && pass_now) || (count_r >= max_it)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NUM;
          phase_nxt = PH_X;
        end
      end
      S_DONE:  if (done_ready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_X;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        x_r     <= item.x_start;
        y_r     <= item.y_start;
        z_r     <= item.z_start;
        count_r <= '0;
      end
      S_NUM: begin
        numneg_r <= num[NUM_W-1];
        mag_r    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        if (phase_r == PH_X) begin
          xo_r    <= x_r;
          yo_r    <= y_r;
          count_r <= count_r + 1'b1;
          ovf_r   <= 1'b0;
        end
      end
      S_HI:  acc_r <= prod;
      S_ACC: acc_r <= acc_r + {prod[DATA_W-1:0], 32'b0};
      S_FIN: begin
        if (sat) begin
          ovf_r <= 1'b1;
        end
        case (phase_r)
          PH_X:    x_r <= val;
          PH_Y:    y_r <= val;
          default: z_r <= val;
        endcase
      end
      S_CXW: passx_r <= pass_now;
      S_CYW: begin
        if (ovf_r) begin
          status_r <= ST_OVF;
        end else if (passx_r && pass_now) begin
          status_r <= ST_CONV;
        end else begin
          status_r <= ST_LIMIT;
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign done_valid = (state_r == S_DONE);
  assign result     = '{x_result: x_r, y_result: y_r, z_result: z_r,
                        sweep_count: count_r, status: status_r};

endmodule

FILE: hdl/gauss_seidel_3x3_solver_top.sv
// Top level of the 3x3 Gauss-Seidel solver: configuration registers, input
// and output channels, output register. Depends on gss_pkg and gss_seq.
//
// Use: write tolerance (address 0, unsigned Q0.32) and max_iterations
// (address 4) over the APB-style port while idle. Send a starting guess
// (x, y, z) on in_data with in_valid; it is accepted when in_stall is low.
// One result transaction follows on out_data with out_valid: final x, y, z,
// the sweep count and the status (converged, overflow, limit).
// Each sweep runs three updates through the one shared 32x32 multiplier
// (numerator, low and high partial product, accumulate, round and
// saturate), then the relative change test. in_stall stays high while
// a guess is in work, so one item is handled at a time.
// The finished result sits in the output register, and a new item is taken
// while it waits; if out_stall keeps that register full, the next item
// holds at its end until the register frees.
// Reset clears control state and loads tolerance 42950, max_iterations 1000.
module gauss_seidel_3x3_solver_top
  import gss_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]      tol_r;
  logic [CNT_W-1:0] max_it_r;
  logic             out_valid_r;
  out_t             out_data_r;
  logic             busy, done_valid, done_ready, start, cfg_wr;
  out_t             result;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == REG_MAXIT) ? 32'(max_it_r) : tol_r;
  assign in_stall   = busy;
  assign start      = in_valid && !busy;
  assign done_ready = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  gss_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .item       (in_data),
    .tol        (tol_r),
    .max_it     (max_it_r),
    .busy       (busy),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      max_it_r <= MAXIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TOL) begin
        tol_r <= pwdata;
      end else begin
        max_it_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_data_r <= result;
    end
  end

endmodule
